/* design/sfe_pkg.sv */
// ----------------------------------------------------------------------------
// sfe_pkg: shared constants, types and coefficient tables
// Frame and transform sizes, fixed-point helpers, and the Hann and twiddle
// tables, which are computed at elaboration time.
// ----------------------------------------------------------------------------
package sfe_pkg;

  localparam int FRAME_LEN = 64;
  localparam int FFT_LEN   = 64;
  localparam int NUM_BINS  = FFT_LEN / 2 + 1;
  localparam int WIN_AW    = $clog2(FRAME_LEN);
  localparam int FFT_AW    = $clog2(FFT_LEN);
  localparam int BIN_W     = 6;
  localparam int CNT_W     = 11;
  localparam int MUL_W     = 25;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int ACC_W     = 32 + FFT_AW;
  localparam int POW_W     = 48;

  localparam logic [1:0] REG_GAIN  = 2'd0;
  localparam logic [1:0] REG_PREEM = 2'd1;
  localparam logic [1:0] REG_HOP   = 2'd2;

  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  typedef logic signed [15:0] coef_t;
  typedef coef_t win_tab_t [FRAME_LEN];
  typedef coef_t fft_tab_t [FFT_LEN];

  // Quotient rounded toward zero, by shift and subtract on the magnitude.
  function automatic longint trunc_div(longint num, longint den);
    longint mag;
    longint q;
    longint rem;
    bit     neg;
    neg = (num < 0);
    mag = neg ? -num : num;
    q   = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem <<< 1) | ((mag >>> b) & 64'sd1);
      q   = q <<< 1;
      if (rem >= den) begin
        rem = rem - den;
        q   = q | 64'sd1;
      end
    end
    return neg ? -q : q;
  endfunction

  // Taylor series in Q30: cos up to the x^14 term, sin up to the x^13 term.
  function automatic longint series_q30(longint x, bit odd);
    longint x2;
    longint term;
    longint sum;
    longint n;
    x2   = (x * x) >>> 30;
    term = odd ? x : (64'sd1 <<< 30);
    sum  = term;
    n    = odd ? 64'sd1 : 64'sd0;
    for (int j = 0; j < 7; j++) begin
      if (n < 13) begin
        term = -trunc_div(trunc_div(term * x2, 64'sd1 <<< 30), (n + 1) * (n + 2));
        sum  = sum + term;
        n    = n + 2;
      end
    end
    return sum;
  endfunction

  function automatic longint cos_q30(logic [31:0] phase);
    longint x;
    x = (longint'(phase[29:0]) * HALF_PI_Q30) >>> 30;
    case (phase[31:30])
      2'd0:    return series_q30(x, 1'b0);
      2'd1:    return -series_q30(x, 1'b1);
      2'd2:    return -series_q30(x, 1'b0);
      default: return series_q30(x, 1'b1);
    endcase
  endfunction

  function automatic coef_t q30_to_q15(longint v);
    longint r;
    r = (v + (64'sd1 <<< 14)) >>> 15;
    if (r > 32767)  return 16'sh7FFF;
    if (r < -32768) return 16'sh8000;
    return coef_t'(r);
  endfunction

  // The frame length is a power of two, so the phase step is a shift. One
  // minus the cosine is never negative, so halving is a shift as well.
  function automatic win_tab_t mk_hann();
    win_tab_t t;
    longint ph;
    for (int i = 0; i < FRAME_LEN; i++) begin
      ph   = (longint'(2 * i + 1)) <<< (31 - WIN_AW);
      t[i] = q30_to_q15(((64'sd1 <<< 30) - cos_q30(ph[31:0])) >>> 1);
    end
    return t;
  endfunction

  function automatic fft_tab_t mk_tw(bit sine);
    fft_tab_t t;
    longint ph;
    logic [31:0] p32;
    for (int i = 0; i < FFT_LEN; i++) begin
      ph  = longint'(i) <<< (32 - FFT_AW);
      p32 = ph[31:0];
      if (sine) p32 = p32 - 32'h4000_0000;
      t[i] = q30_to_q15(cos_q30(p32));
    end
    return t;
  endfunction

  localparam win_tab_t HANN   = mk_hann();
  localparam fft_tab_t TW_COS = mk_tw(1'b0);
  localparam fft_tab_t TW_SIN = mk_tw(1'b1);

endpackage

/* design/stft_power_spectrum_frontend_core.sv */
// ----------------------------------------------------------------------------
// stft_power_spectrum_frontend_core: STFT power spectrum front end
// Gain, framing, pre-emphasis, Hann window, 64-point DFT and bin power.
// ----------------------------------------------------------------------------
// Each input request carries one signed Q1.15 sample, which is scaled by the
// Q8.8 input gain and stored in a 64-entry circular sample window before the
// next request is taken. The first window is due after 64 samples and every
// later one hop_length samples on (zero acts as one). When a window is due,
// the block fills a work buffer with the pre-emphasized, Hann-windowed frame
// (read, pre-emphasis product, window product and write per sample) and then
// computes 33 power bins directly (a cosine and a sine product for each of 64
// terms per bin, then the two squares and their sum), during which in_tready
// is low. Every product is formed by one shared 25x25 multiplier. Each result
// request carries bin_index and power in out_tdata and marks the final bin
// with out_tlast. A finished bin waits in an output register, and the next
// input request can be taken while the last bin of a frame is still waiting.
// Configuration writes are always accepted and must be made only while the
// block is idle.
// ----------------------------------------------------------------------------
module stft_power_spectrum_frontend_core
  import sfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // [5:0] bin_index, [53:6] power, [55:54] zero
  output logic        out_tlast,   // last_bin
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_GAIN  = 4'd1;
  localparam logic [3:0] S_GSAT  = 4'd2;
  localparam logic [3:0] S_F_RD  = 4'd3;
  localparam logic [3:0] S_F_MUL = 4'd4;
  localparam logic [3:0] S_F_EMP = 4'd5;
  localparam logic [3:0] S_F_WIN = 4'd6;
  localparam logic [3:0] S_F_WR  = 4'd7;
  localparam logic [3:0] S_D_RD  = 4'd8;
  localparam logic [3:0] S_D_RE  = 4'd9;
  localparam logic [3:0] S_D_IM  = 4'd10;
  localparam logic [3:0] S_D_ACC = 4'd11;
  localparam logic [3:0] S_D_PR  = 4'd12;
  localparam logic [3:0] S_D_PI  = 4'd13;
  localparam logic [3:0] S_D_SUM = 4'd14;
  localparam logic [3:0] S_D_OUT = 4'd15;

  logic [3:0]  state_r, state_nxt;

  // Configuration registers.
  logic [15:0] gain_r;
  logic [14:0] coeff_r;
  logic [9:0]  hop_r;

  logic signed [15:0] sample_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [WIN_AW-1:0]  wptr_r;
  logic [FRAME_LEN-1:0] vld_r;
  logic               vld_q_r;

  logic [WIN_AW-1:0]  i_r;
  logic signed [15:0] x_r, prev_r, e_r;
  logic [FFT_AW-1:0]  n_r, idx_r;
  logic [BIN_W-1:0]   k_r;
  logic signed [ACC_W-1:0] acc_re_r, acc_im_r;
  logic [POW_W-1:0]   pow_r;

  logic               out_valid_r;
  logic [BIN_W-1:0]   out_bin_r;
  logic [POW_W-1:0]   out_pow_r;
  logic               out_last_r;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;

  logic [15:0] win_rdata, wrk_rdata;
  logic        win_we, win_re, wrk_we, wrk_re;
  logic [15:0] wrk_wdata;

  logic signed [PROD_W-1:0] gain_rnd, emp_diff, emp_rnd, win_rnd;
  logic signed [15:0] scaled, emph, x_cur;
  logic signed [ACC_W-1:0] re_rnd, im_rnd;
  logic signed [MUL_W-1:0] re_q, im_q;
  logic [POW_W:0] pow_sum;
  logic        out_load;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= 16'd256;
      coeff_r <= 15'd0;
      hop_r   <= 10'd32;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GAIN:  gain_r  <= cfg_data;
        REG_PREEM: coeff_r <= cfg_data[14:0];
        REG_HOP:   hop_r   <= cfg_data[9:0];
        default:   ;
      endcase
    end
  end

  sfe_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(prod));

  sfe_ram #(.WIDTH(16), .DEPTH(FRAME_LEN)) u_win (
    .clk(clk), .we(win_we), .waddr(wptr_r), .wdata(scaled),
    .re(win_re), .raddr(wptr_r + i_r), .rdata(win_rdata)
  );

  sfe_ram #(.WIDTH(16), .DEPTH(FFT_LEN)) u_wrk (
    .clk(clk), .we(wrk_we), .waddr(FFT_AW'(i_r)), .wdata(wrk_wdata),
    .re(wrk_re), .raddr(n_r), .rdata(wrk_rdata)
  );

  // Fixed-point rounding, with saturation of the gain and pre-emphasis results.
  always_comb begin
    gain_rnd = (prod + PROD_W'(128)) >>> 8;
    if (gain_rnd > PROD_W'(32767))       scaled = 16'sh7FFF;
    else if (gain_rnd < -PROD_W'(32768)) scaled = 16'sh8000;
    else                                 scaled = gain_rnd[15:0];

    emp_diff = (PROD_W'(x_r) <<< 15) - prod;
    emp_rnd  = (emp_diff + PROD_W'(16384)) >>> 15;
    if (emp_rnd > PROD_W'(32767))       emph = 16'sh7FFF;
    else if (emp_rnd < -PROD_W'(32768)) emph = 16'sh8000;
    else                                emph = emp_rnd[15:0];

    win_rnd   = (prod + PROD_W'(16384)) >>> 15;
    wrk_wdata = win_rnd[15:0];

    x_cur  = vld_q_r ? signed'(win_rdata) : 16'sd0;
    re_rnd = (acc_re_r + ACC_W'(16384)) >>> 15;
    im_rnd = (acc_im_r + ACC_W'(16384)) >>> 15;
    re_q   = MUL_W'(re_rnd);
    im_q   = MUL_W'(im_rnd);
    pow_sum = {1'b0, pow_r} + (POW_W + 1)'(prod);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_GAIN: begin
        mul_a = MUL_W'(sample_r);
        mul_b = MUL_W'(gain_r);
      end
      S_F_MUL: begin
        mul_a = MUL_W'(coeff_r);
        mul_b = (i_r == '0) ? MUL_W'(x_cur) : MUL_W'(prev_r);
      end
      S_F_WIN: begin
        mul_a = MUL_W'(e_r);
        mul_b = MUL_W'(HANN[i_r]);
      end
      S_D_RE: begin
        mul_a = MUL_W'(signed'(wrk_rdata));
        mul_b = MUL_W'(TW_COS[idx_r]);
      end
      S_D_IM: begin
        mul_a = MUL_W'(signed'(wrk_rdata));
        mul_b = MUL_W'(TW_SIN[idx_r]);
      end
      S_D_PR: begin
        mul_a = re_q;
        mul_b = re_q;
      end
      S_D_PI: begin
        mul_a = im_q;
        mul_b = im_q;
      end
      default: ;
    endcase
  end

  assign win_we   = (state_r == S_GSAT);
  assign win_re   = (state_r == S_F_RD);
  assign wrk_we   = (state_r == S_F_WR);
  assign wrk_re   = (state_r == S_D_RD);
  assign out_load = (state_r == S_D_OUT) && (!out_valid_r || out_tready);

  // The countdown reloads from the hop length; zero counts as one.
  always_comb begin
    cnt_nxt = cnt_r;
    if (state_r == S_GSAT) begin
      if (cnt_r > CNT_W'(1))   cnt_nxt = cnt_r - CNT_W'(1);
      else if (hop_r == '0)    cnt_nxt = CNT_W'(1);
      else                     cnt_nxt = CNT_W'(hop_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_GAIN;
      S_GAIN:  state_nxt = S_GSAT;
      S_GSAT:  state_nxt = (cnt_r > CNT_W'(1)) ? S_IDLE : S_F_RD;
      S_F_RD:  state_nxt = S_F_MUL;
      S_F_MUL: state_nxt = S_F_EMP;
      S_F_EMP: state_nxt = S_F_WIN;
      S_F_WIN: state_nxt = S_F_WR;
      S_F_WR:  state_nxt = (i_r == WIN_AW'(FRAME_LEN - 1)) ? S_D_RD : S_F_RD;
      S_D_RD:  state_nxt = S_D_RE;
      S_D_RE:  state_nxt = S_D_IM;
      S_D_IM:  state_nxt = S_D_ACC;
      S_D_ACC: state_nxt = (n_r == FFT_AW'(FFT_LEN - 1)) ? S_D_PR : S_D_RD;
      S_D_PR:  state_nxt = S_D_PI;
      S_D_PI:  state_nxt = S_D_SUM;
      S_D_SUM: state_nxt = S_D_OUT;
      S_D_OUT: begin
        if (out_load) begin
          state_nxt = (k_r == BIN_W'(NUM_BINS - 1)) ? S_IDLE : S_D_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= CNT_W'(FRAME_LEN);
      wptr_r      <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      n_r         <= '0;
      idx_r       <= '0;
      k_r         <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (win_we) begin
        vld_r[wptr_r] <= 1'b1;
        wptr_r        <= wptr_r + WIN_AW'(1);
        i_r           <= '0;
      end
      if (state_r == S_F_WR) begin
        i_r   <= i_r + WIN_AW'(1);
        n_r   <= '0;
        idx_r <= '0;
        k_r   <= '0;
      end
      if (state_r == S_D_ACC) begin
        n_r   <= n_r + FFT_AW'(1);
        idx_r <= idx_r + FFT_AW'(k_r);
      end
      if (out_load) begin
        k_r <= k_r + BIN_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) sample_r <= signed'(in_tdata);
    if (win_re) vld_q_r <= vld_r[wptr_r + i_r];
    if (state_r == S_F_MUL) x_r <= x_cur;
    if (state_r == S_F_EMP) begin
      e_r    <= emph;
      prev_r <= x_r;
    end
    if (state_r == S_F_WR || (out_load && k_r != BIN_W'(NUM_BINS - 1))) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end
    if (state_r == S_D_IM)  acc_re_r <= acc_re_r + ACC_W'(prod);
    if (state_r == S_D_ACC) acc_im_r <= acc_im_r - ACC_W'(prod);
    if (state_r == S_D_PI)  pow_r <= prod[POW_W-1:0];
    if (state_r == S_D_SUM) begin
      pow_r <= pow_sum[POW_W] ? {POW_W{1'b1}} : pow_sum[POW_W-1:0];
    end
    if (out_load) begin
      out_bin_r  <= k_r;
      out_pow_r  <= pow_r;
      out_last_r <= (k_r == BIN_W'(NUM_BINS - 1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_pow_r, out_bin_r};
  assign out_tlast  = out_last_r;

endmodule

/* design/sfe_ram.sv */
// ----------------------------------------------------------------------------
// sfe_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sfe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/sfe_mul.sv */
// ----------------------------------------------------------------------------
// sfe_mul: shared signed multiplier
// One registered signed product per cycle, used by every multiplying step of the sequencer.
// ----------------------------------------------------------------------------
module sfe_mul
  import sfe_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] p_r
);

  logic signed [PROD_W-1:0] p_nxt;

  assign p_nxt = PROD_W'(a) * PROD_W'(b);

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

/* design/sfe_checker.sv */
// ----------------------------------------------------------------------------
// sfe_checker: port-level checks for the power spectrum front end
// Watches the top-level ports and is attached to it by a bind statement.
// ----------------------------------------------------------------------------
module sfe_checker
  import sfe_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tlast
);

  // A result that is not taken stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The block works on one sample at a time.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while busy");

  // Bin numbers stay within the half spectrum.
  a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[5:0] <= 6'(NUM_BINS - 1))
    else $error("bin index out of range");

  // The frame marker sits exactly on the final bin.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[5:0] == 6'(NUM_BINS - 1))))
    else $error("last-bin flag misplaced");

endmodule

bind stft_power_spectrum_frontend_core sfe_checker u_sfe_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast)
);

/* sim/stft_power_spectrum_frontend_core_test.sv */
// ----------------------------------------------------------------------------
// stft_power_spectrum_frontend_core_test: power spectrum front end testbench
// Streams audio samples through several register settings, predicts every
// power bin with an independent fixed-point model of the gain, framing,
// pre-emphasis, Hann window and DFT, and compares each result request field
// by field while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module stft_power_spectrum_frontend_core_test
  import sfe_pkg::*;
();

  // One predicted power bin.
  typedef struct {
    logic [5:0]  bin;
    logic [47:0] power;
    logic        last;
  } bin_power_t;

  // One register setting and how many samples are streamed under it.
  typedef struct {
    int gain;
    int preem;
    int hop;
    int count;
  } setting_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_GAIN;
  logic [15:0] cfg_data = '0;

  stft_power_spectrum_frontend_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [15:0] sample
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [5:0] bin_index, [53:6] power, [55:54] zero
    .out_tlast  (out_tlast),   // last_bin
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // Predictor state: register copies, the sample window (oldest first) and
  // the countdown to the next analysis window.
  int         model_gain;
  int         model_preem;
  int         model_hop;
  int         frame_samples [FRAME_LEN];
  int         window_countdown;
  int         hann_coef [FRAME_LEN];
  int         twiddle_cos [FFT_LEN];
  int         twiddle_sin [FFT_LEN];
  bin_power_t pending_bins [$];

  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;   // while set, neither side idles
  int  ready_stall = 0;

  localparam int WATCHDOG_LIMIT = 40000;

  // Round half up, then shift right with floor semantics.
  function automatic longint round_shift(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Truncated Taylor series in Q30: cos up to the x^14 term, sin up to the x^13 term.
  function automatic longint taylor_q30(longint x, bit odd);
    longint x2;
    longint term;
    longint sum;
    longint n;
    x2   = (x * x) >>> 30;
    term = odd ? x : (64'sd1 <<< 30);
    sum  = term;
    n    = odd ? 1 : 0;
    while (n < 13) begin
      term = -((term * x2) / (64'sd1 <<< 30)) / ((n + 1) * (n + 2));
      sum  = sum + term;
      n    = n + 2;
    end
    return sum;
  endfunction

  // Cosine of a phase given in 2^-32 turns, Q30.
  function automatic longint phase_cos_q30(logic [31:0] phase);
    longint x;
    x = ({34'b0, phase[29:0]} * 64'sd1686629713) >>> 30;
    case (phase[31:30])
      2'd0:    return taylor_q30(x, 1'b0);
      2'd1:    return -taylor_q30(x, 1'b1);
      2'd2:    return -taylor_q30(x, 1'b0);
      default: return taylor_q30(x, 1'b1);
    endcase
  endfunction

  function automatic void build_coef_tables();
    longint ph;
    logic [31:0] p32;
    for (int i = 0; i < FRAME_LEN; i++) begin
      ph = (longint'(2 * i + 1) <<< 32) / (2 * FRAME_LEN);
      hann_coef[i] = int'(clip16(round_shift(
        ((64'sd1 <<< 30) - phase_cos_q30(ph[31:0])) / 2, 15)));
    end
    for (int i = 0; i < FFT_LEN; i++) begin
      ph  = (longint'(i) <<< 32) / FFT_LEN;
      p32 = ph[31:0];
      twiddle_cos[i] = int'(clip16(round_shift(phase_cos_q30(p32), 15)));
      twiddle_sin[i] = int'(clip16(round_shift(phase_cos_q30(p32 - 32'h4000_0000), 15)));
    end
  endfunction

  // Pre-emphasis, Hann window and power of each DFT bin for the current frame.
  function automatic void predict_spectrum();
    longint     work [FFT_LEN];
    longint     x;
    longint     prev;
    longint     e;
    longint     re;
    longint     im;
    longint     mag_re;
    longint     mag_im;
    logic [63:0] p;
    int         idx;
    bin_power_t bp;
    prev = 0;
    for (int i = 0; i < FFT_LEN; i++) work[i] = 0;
    for (int i = 0; i < FRAME_LEN && i < FFT_LEN; i++) begin
      x = frame_samples[i];
      if (i == 0) e = x * (32768 - model_preem);
      else        e = x * 32768 - longint'(model_preem) * prev;
      e = clip16(round_shift(e, 15));
      work[i] = longint'(16'(round_shift(e * hann_coef[i], 15)));
      if (work[i] > 32767) work[i] = work[i] - 65536;
      prev = x;
    end
    for (int k = 0; k < NUM_BINS; k++) begin
      re  = 0;
      im  = 0;
      idx = 0;
      for (int n = 0; n < FFT_LEN; n++) begin
        re  = re + work[n] * twiddle_cos[idx];
        im  = im - work[n] * twiddle_sin[idx];
        idx = (idx + k) % FFT_LEN;
      end
      mag_re = round_shift(re, 15);
      mag_im = round_shift(im, 15);
      if (mag_re < 0) mag_re = -mag_re;
      if (mag_im < 0) mag_im = -mag_im;
      p = 64'(mag_re * mag_re) + 64'(mag_im * mag_im);
      if (p > 64'hFFFF_FFFF_FFFF) p = 64'hFFFF_FFFF_FFFF;
      bp.bin   = 6'(k);
      bp.power = p[47:0];
      bp.last  = (k == NUM_BINS - 1);
      pending_bins = {pending_bins, bp};
    end
  endfunction

  // Scale one accepted sample into the frame and emit a spectrum when due.
  function automatic void predict_sample(logic signed [15:0] s);
    longint scaled;
    scaled = clip16(round_shift(longint'(s) * model_gain, 8));
    for (int i = 0; i < FRAME_LEN - 1; i++) frame_samples[i] = frame_samples[i + 1];
    frame_samples[FRAME_LEN - 1] = int'(scaled);
    if (window_countdown > 1) begin
      window_countdown--;
    end else begin
      window_countdown = (model_hop == 0) ? 1 : model_hop;
      predict_spectrum();
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Idle gap drawn per request; none at all during calm stretches.
  function automatic int draw_gap();
    if ($urandom_range(0, 15) == 0) calm = ~calm;
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  // Send one sample request. The valid stays high across back-to-back
  // requests, so it is only lowered when a gap follows.
  task automatic send_sample(input logic [15:0] s);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_sample(s);
  endtask

  task automatic write_register(input logic [1:0] index, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= 16'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (index)
      REG_GAIN:  model_gain  = value & 16'hFFFF;
      REG_PREEM: model_preem = value & 15'h7FFF;
      REG_HOP:   model_hop   = value & 10'h3FF;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Wait for every predicted bin, then let the block settle.
  task automatic drain();
    while (pending_bins.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Result side: random stalls on out_tready, and the field-by-field check.
  always @(posedge clk) begin
    bin_power_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_bins.size() == 0) begin
        report_mismatch($sformatf("unexpected bin %0d", out_tdata[5:0]));
      end else begin
        want = pending_bins.pop_front();
        if (out_tdata[5:0] !== want.bin)
          report_mismatch($sformatf("bin_index %0d, want %0d", out_tdata[5:0], want.bin));
        if (out_tdata[53:6] !== want.power)
          report_mismatch($sformatf("bin %0d power %0d, want %0d",
                                    want.bin, out_tdata[53:6], want.power));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("bin %0d last_bin %b, want %b",
                                    want.bin, out_tlast, want.last));
        if (out_tdata[55:54] !== 2'b00)
          report_mismatch("padding bits of out_tdata not zero");
      end
      ready_stall = draw_gap();
      out_tready <= (ready_stall == 0);
    end else if (rst_n) begin
      if (ready_stall > 0) ready_stall--;
      out_tready <= (ready_stall == 0);
    end
  end

  // Watchdog: ends the run when nothing has been accepted for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired at %0t", $time);
      $display("Some tests failed");
      $finish;
    end
  end

  // Directed samples right after reset: field extremes and bit patterns.
  // All of them come before the first window is due, so no bin may appear.
  logic [15:0] directed_samples [24] = '{
    16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF, 16'h4000,
    16'hC000, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 16'h7FFE,
    16'h8001, 16'h0F0F, 16'hF0F0, 16'h3333, 16'hCCCC, 16'h0100,
    16'hFF80, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h1234
  };

  setting_t settings [7];

  initial begin
    model_gain       = 256;
    model_preem      = 0;
    model_hop        = 32;
    window_countdown = FRAME_LEN;
    for (int i = 0; i < FRAME_LEN; i++) frame_samples[i] = 0;
    build_coef_tables();

    // The hop of 1023 comes last, since its reload would starve later phases.
    settings[0] = '{256, 0, 16, 60};
    settings[1] = '{65535, 32767, 8, 40};
    settings[2] = '{0, 12000, 1, 6};
    settings[3] = '{int'($urandom_range(0, 65535)), int'($urandom_range(0, 32767)), 0, 6};
    settings[4] = '{300, 29000, 24, 100};
    settings[5] = '{int'($urandom_range(0, 1024)), int'($urandom_range(0, 32767)),
                    int'($urandom_range(4, 40)), 60};
    settings[6] = '{512, 0, 1023, 20};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_samples[i]) send_sample(directed_samples[i]);
    in_tvalid <= 1'b0;
    drain();

    foreach (settings[p]) begin
      write_register(REG_GAIN, settings[p].gain);
      write_register(REG_PREEM, settings[p].preem);
      write_register(REG_HOP, settings[p].hop);
      for (int i = 0; i < settings[p].count; i++) begin
        case ($urandom_range(0, 7))
          0:       send_sample($urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
          1:       send_sample(16'($signed($urandom_range(0, 64)) - 32));
          default: send_sample(16'($urandom_range(0, 65535)));
        endcase
      end
      in_tvalid <= 1'b0;
      drain();
    end

    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
